[sv/sfd_pkg.sv]
// package: word types, config codes and arithmetic helpers for the stereo feedback delay
package sfd_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int DL_W       = 14;
    localparam int FB_W       = 16;
    localparam int WET_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int RECIP_SHIFT = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PONG     = 2'd3;

    localparam logic [DL_W-1:0]  RST_DELAY_LENGTH  = 14'd1031;
    localparam logic [FB_W-1:0]  RST_FEEDBACK_GAIN = 16'd16119;
    localparam logic [WET_W-1:0] RST_WET_GAIN      = 17'd16448;

    localparam logic signed [SAMPLE_W-1:0] LOUD_HIGH = 32'sd32;
    localparam logic signed [SAMPLE_W-1:0] LOUD_LOW  = -32'sd32;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic                       input_present;
        logic                       frame_last;
    } t_in_word;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       ringing;
    } t_out_word;

    typedef struct packed {
        logic [FB_W-1:0]  feedback_gain;
        logic [WET_W-1:0] wet_gain;
        logic             ping_pong;
        logic             busy;
    } t_cfg;

    // floor(a * g / 2^frac), wrapped to the sample width
    function automatic logic signed [SAMPLE_W-1:0] scale(
        input logic signed [SAMPLE_W-1:0] a,
        input logic [WET_W-1:0]           g,
        input int                         frac
    );
        logic signed [SAMPLE_W+WET_W:0] p;
        logic signed [SAMPLE_W+WET_W:0] s;
        p = a * $signed({1'b0, g});
        s = p >>> frac;
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic logic is_loud(input logic signed [SAMPLE_W-1:0] v);
        return (v > LOUD_HIGH) || (v < LOUD_LOW);
    endfunction

endpackage

[sv/sfd_ram.sv]
// generic simple dual-port ram with registered read
module sfd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sfd_cfg.sv]
// configuration registers and delay length reduction modulo the line depth
module sfd_cfg #(
    parameter int DELAY_DEPTH = 16384
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output sfd_pkg::t_cfg                        o_cfg,
    output logic [$clog2(DELAY_DEPTH)-1:0]       o_delay_mod
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int DL_W = sfd_pkg::DL_W;
    localparam int QW = DL_W + 1;
    localparam logic [sfd_pkg::RECIP_SHIFT-1:0] RECIP =
        sfd_pkg::RECIP_SHIFT'((64'd1 << sfd_pkg::RECIP_SHIFT) / DELAY_DEPTH);
    localparam logic [DL_W-1:0] RST_Q =
        DL_W'(sfd_pkg::RST_DELAY_LENGTH / DELAY_DEPTH);
    localparam logic [AW-1:0] RST_MOD =
        AW'(sfd_pkg::RST_DELAY_LENGTH % DELAY_DEPTH);

    logic [DL_W-1:0]                r_delay_length;
    logic [sfd_pkg::FB_W-1:0]       r_feedback_gain;
    logic [sfd_pkg::WET_W-1:0]      r_wet_gain;
    logic                           r_ping_pong;
    logic [DL_W-1:0]                r_q;
    logic [AW-1:0]                  r_delay_mod;
    logic [1:0]                     r_busy;

    logic [DL_W+sfd_pkg::RECIP_SHIFT-1:0] recip_prod;
    logic [QW-1:0]                         rem_est;
    logic [31:0]                           rem_fix;
    logic [DL_W-1:0]                       n_q;

    // quotient estimate is exact or one short, so one correction step suffices
    always_comb begin
        recip_prod = DL_W'(r_delay_length) * RECIP;
        n_q        = DL_W'(recip_prod >> sfd_pkg::RECIP_SHIFT);
        rem_est    = QW'({1'b0, r_delay_length}) - QW'(64'(r_q) * 64'(DELAY_DEPTH));
        rem_fix    = (32'(rem_est) >= 32'(DELAY_DEPTH)) ?
                     32'(rem_est) - 32'(DELAY_DEPTH) : 32'(rem_est);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= sfd_pkg::RST_DELAY_LENGTH;
            r_feedback_gain <= sfd_pkg::RST_FEEDBACK_GAIN;
            r_wet_gain      <= sfd_pkg::RST_WET_GAIN;
            r_ping_pong     <= 1'b0;
            r_q             <= RST_Q;
            r_delay_mod     <= RST_MOD;
            r_busy          <= 2'd0;
        end else begin
            r_q         <= n_q;
            r_delay_mod <= AW'(rem_fix);
            if (r_busy != 2'd0) begin
                r_busy <= r_busy - 2'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sfd_pkg::CFG_DELAY_LENGTH: begin
                        r_delay_length <= i_cfg_data[DL_W-1:0];
                        r_busy         <= 2'd2;
                    end
                    sfd_pkg::CFG_FEEDBACK_GAIN: begin
                        r_feedback_gain <= i_cfg_data[sfd_pkg::FB_W-1:0];
                    end
                    sfd_pkg::CFG_WET_GAIN: begin
                        r_wet_gain <= i_cfg_data[sfd_pkg::WET_W-1:0];
                    end
                    sfd_pkg::CFG_PING_PONG: begin
                        r_ping_pong <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_cfg.feedback_gain = r_feedback_gain;
    assign o_cfg.wet_gain      = r_wet_gain;
    assign o_cfg.ping_pong     = r_ping_pong;
    assign o_cfg.busy          = (r_busy != 2'd0);
    assign o_delay_mod         = r_delay_mod;

endmodule

[sv/stereo_feedback_delay_unit.sv]
// top level: stereo feedback delay with ping-pong, one word per cycle unless held
//
// Takes one stereo sample word per clock while not stalled and returns one result
// word per sample through the mixing stage register and then the output register.
// A word is read from the delay ram in the cycle it is taken, then mixed and
// written back when the mixing stage commits, and the echo times wet gain sits in
// the output register; the feedback loop at a delay length of one is closed by a
// bypass from the mixing stage. The delay store reads as zero after reset without
// a clearing pass: a fill count marks which entries have been written. A write of
// delay_length holds off input while it is reduced modulo the depth.
module stereo_feedback_delay_unit #(
    parameter int DELAY_DEPTH = 16384,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfd_pkg::t_in_word              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfd_pkg::t_out_word             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int FW   = $clog2(DELAY_DEPTH + 1);
    localparam int SW   = sfd_pkg::SAMPLE_W;
    localparam int HIST = (DELAY_DEPTH < 4) ? DELAY_DEPTH - 1 : 3;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X   = (AW+1)'(DELAY_DEPTH);

    sfd_pkg::t_cfg      cfg;
    logic [AW-1:0]      delay_mod;

    logic               in_accept;
    logic               s1_commit;
    logic               out_free;
    logic               s1_free;
    logic [AW:0]        rp_sum;
    logic [AW-1:0]      rp;
    logic               rp_hit;
    logic               rp_byp;
    logic [2*SW-1:0]    ram_rdata;

    logic [AW-1:0]      r_wp;
    logic [FW-1:0]      r_fill;
    logic               r_s1_valid;
    sfd_pkg::t_in_word  r_s1_data;
    logic [AW-1:0]      r_s1_wp;
    logic               r_s1_hit;
    logic               r_s1_byp;
    logic [2*SW-1:0]    r_byp_data;
    logic [HIST-1:0]    r_loud_hist;
    logic               r_out_valid;
    sfd_pkg::t_out_word r_out_data;

    logic signed [SW-1:0] in_l, in_r, rd_l, rd_r, fb_l, fb_r, half;
    logic signed [SW-1:0] n_new_l, n_new_r;
    logic                 cur_loud;
    sfd_pkg::t_out_word   n_out_data;

    sfd_cfg #(
        .DELAY_DEPTH(DELAY_DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_delay_mod(delay_mod)
    );

    sfd_ram #(
        .WIDTH(2*SW),
        .DEPTH(DELAY_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (s1_commit),
        .i_waddr(r_s1_wp),
        .i_wdata({n_new_l, n_new_r}),
        .i_re   (in_accept),
        .i_raddr(rp),
        .o_rdata(ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_commit  = r_s1_valid && out_free;
    assign s1_free    = !r_s1_valid || out_free;
    assign o_in_stall = !s1_free || cfg.busy;
    assign in_accept  = i_in_valid && !o_in_stall;

    // read position and whether it was written since reset or is still in flight
    always_comb begin
        rp_sum = {1'b0, r_wp} + DEPTH_X - {1'b0, delay_mod};
        rp     = (rp_sum >= DEPTH_X) ? AW'(rp_sum - DEPTH_X) : rp_sum[AW-1:0];
        rp_hit = ({1'b0, rp} < (AW+1)'(r_fill));
        rp_byp = r_s1_valid && (rp == r_s1_wp);
    end

    // mixing stage
    always_comb begin
        in_l = r_s1_data.input_present ? r_s1_data.in_left  : '0;
        in_r = r_s1_data.input_present ? r_s1_data.in_right : '0;
        if (r_s1_byp) begin
            rd_l = r_byp_data[2*SW-1:SW];
            rd_r = r_byp_data[SW-1:0];
        end else if (r_s1_hit) begin
            rd_l = ram_rdata[2*SW-1:SW];
            rd_r = ram_rdata[SW-1:0];
        end else begin
            rd_l = '0;
            rd_r = '0;
        end
        fb_l = sfd_pkg::scale(rd_l, {1'b0, cfg.feedback_gain}, FRAC_BITS);
        fb_r = sfd_pkg::scale(rd_r, {1'b0, cfg.feedback_gain}, FRAC_BITS);
        half = (in_l + in_r) >>> 1;
        if (cfg.ping_pong) begin
            n_new_l = half + fb_r;
            n_new_r = fb_l;
        end else begin
            n_new_l = in_l + fb_l;
            n_new_r = in_r + fb_r;
        end
        cur_loud = sfd_pkg::is_loud(n_new_l) || sfd_pkg::is_loud(n_new_r);
        n_out_data.out_left  = sfd_pkg::scale(rd_l, cfg.wet_gain, FRAC_BITS);
        n_out_data.out_right = sfd_pkg::scale(rd_r, cfg.wet_gain, FRAC_BITS);
        n_out_data.ringing   = (r_s1_data.frame_last && !r_s1_data.input_present) ?
                               (cur_loud || (|r_loud_hist)) : r_s1_data.input_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_s1_valid  <= 1'b0;
            r_loud_hist <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_wp <= (r_wp == LAST_ADDR) ? '0 : r_wp + 1'b1;
            end
            if (s1_free) begin
                r_s1_valid <= in_accept;
            end
            if (s1_commit) begin
                if (r_fill != FW'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
                for (int i = HIST - 1; i > 0; i--) begin
                    r_loud_hist[i] <= r_loud_hist[i-1];
                end
                r_loud_hist[0] <= cur_loud;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_data  <= i_in_data;
            r_s1_wp    <= r_wp;
            r_s1_hit   <= rp_hit;
            r_s1_byp   <= rp_byp;
            r_byp_data <= {n_new_l, n_new_r};
        end
        if (s1_commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_delay_write_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == sfd_pkg::CFG_DELAY_LENGTH)) |=> o_in_stall)
        else $error("input taken while delay length is being reduced");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fill) <= 32'(DELAY_DEPTH)))
        else $error("fill count beyond line depth");

    a_commit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_commit |=> r_out_valid)
        else $error("mixed word lost on the way to the output register");

    a_stalled_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_wp)))
        else $error("mixing stage changed while held");

endmodule

[tb/sv/tb_top.sv]
// testbench: directed and random sample words through the stereo feedback delay, checked per word
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH    = 16384;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 8;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    sfd_pkg::t_in_word              in_word   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    sfd_pkg::t_out_word             out_word;
    logic                           cfg_we    = 1'b0;
    logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [sfd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // echo model state
    logic [sfd_pkg::SAMPLE_W-1:0] line_left  [LINE_DEPTH];
    logic [sfd_pkg::SAMPLE_W-1:0] line_right [LINE_DEPTH];
    logic [sfd_pkg::DL_W-1:0]     wr_ptr;
    logic [1:0]                   loud_hist  [4];
    logic [sfd_pkg::DL_W-1:0]     delay_len;
    logic [sfd_pkg::FB_W-1:0]     fb_gain;
    logic [sfd_pkg::WET_W-1:0]    wet_gain;
    logic                         ping_pong;

    sfd_pkg::t_out_word pending_words[$];
    int errors       = 0;
    int idle_cycles  = 0;
    int sent_words   = 0;
    int stall_pct    = 0;
    int gap_max      = 0;
    int burst_left   = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    stereo_feedback_delay_unit #(
        .DELAY_DEPTH(LINE_DEPTH),
        .FRAC_BITS(16)
    ) uut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_word),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [sfd_pkg::SAMPLE_W-1:0] frac_mul(
        logic [sfd_pkg::SAMPLE_W-1:0] a,
        logic [sfd_pkg::WET_W-1:0]    g
    );
        longint p;
        p = longint'($signed(a)) * longint'(g);
        p = p >>> 16;
        return p[sfd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic logic is_audible(logic [sfd_pkg::SAMPLE_W-1:0] v);
        return ($signed(v) > 32) || ($signed(v) < -32);
    endfunction

    function automatic sfd_pkg::t_out_word echo_step(sfd_pkg::t_in_word w);
        logic [sfd_pkg::SAMPLE_W-1:0] src_l, src_r, rd_l, rd_r, new_l, new_r, sum;
        logic [sfd_pkg::DL_W-1:0]     rd_ptr;
        sfd_pkg::t_out_word           r;
        int                           i;
        src_l  = w.input_present ? w.in_left  : '0;
        src_r  = w.input_present ? w.in_right : '0;
        rd_ptr = wr_ptr - delay_len;
        rd_l   = line_left[rd_ptr];
        rd_r   = line_right[rd_ptr];
        if (ping_pong) begin
            sum   = src_l + src_r;
            new_l = {sum[sfd_pkg::SAMPLE_W-1], sum[sfd_pkg::SAMPLE_W-1:1]}
                    + frac_mul(rd_r, {1'b0, fb_gain});
            new_r = frac_mul(rd_l, {1'b0, fb_gain});
        end else begin
            new_l = src_l + frac_mul(rd_l, {1'b0, fb_gain});
            new_r = src_r + frac_mul(rd_r, {1'b0, fb_gain});
        end
        line_left[wr_ptr]  = new_l;
        line_right[wr_ptr] = new_r;
        wr_ptr = wr_ptr + 1'b1;
        for (i = 3; i > 0; i--) loud_hist[i] = loud_hist[i-1];
        loud_hist[0] = {is_audible(new_r), is_audible(new_l)};
        r.out_left  = frac_mul(rd_l, wet_gain);
        r.out_right = frac_mul(rd_r, wet_gain);
        if (w.frame_last && !w.input_present) begin
            r.ringing = |{loud_hist[0], loud_hist[1], loud_hist[2], loud_hist[3]};
        end else begin
            r.ringing = w.input_present;
        end
        return r;
    endfunction

    task automatic reset_model();
        int i;
        for (i = 0; i < LINE_DEPTH; i++) begin
            line_left[i]  = '0;
            line_right[i] = '0;
        end
        for (i = 0; i < 4; i++) loud_hist[i] = '0;
        wr_ptr    = '0;
        delay_len = sfd_pkg::RST_DELAY_LENGTH;
        fb_gain   = sfd_pkg::RST_FEEDBACK_GAIN;
        wet_gain  = sfd_pkg::RST_WET_GAIN;
        ping_pong = 1'b0;
    endtask

    function automatic logic [sfd_pkg::SAMPLE_W-1:0] pick_sample(int amp);
        case (amp)
            0: return int'($urandom_range(0, 80)) - 40;
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 6))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return '0;
                    3: return 33;
                    4: return -33;
                    5: return 32;
                    default: return -32;
                endcase
            end
        endcase
    endfunction

    function automatic sfd_pkg::t_in_word make_word(int amp, logic present, logic last);
        sfd_pkg::t_in_word w;
        w.in_left       = pick_sample(amp);
        w.in_right      = pick_sample(amp);
        w.input_present = present;
        w.frame_last    = last;
        return w;
    endfunction

    function automatic sfd_pkg::t_in_word fixed_word(logic [sfd_pkg::SAMPLE_W-1:0] l,
                                                     logic [sfd_pkg::SAMPLE_W-1:0] r,
                                                     logic present, logic last);
        sfd_pkg::t_in_word w;
        w.in_left       = l;
        w.in_right      = r;
        w.input_present = present;
        w.frame_last    = last;
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [sfd_pkg::SAMPLE_W-1:0] got,
                                   logic [sfd_pkg::SAMPLE_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic send_word(sfd_pkg::t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_words.push_back(echo_step(w));
        sent_words++;
    endtask

    task automatic send_paced(sfd_pkg::t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [sfd_pkg::CFG_IDX_W-1:0] idx,
                             logic [sfd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            sfd_pkg::CFG_DELAY_LENGTH:  delay_len = data[sfd_pkg::DL_W-1:0];
            sfd_pkg::CFG_FEEDBACK_GAIN: fb_gain   = data[sfd_pkg::FB_W-1:0];
            sfd_pkg::CFG_WET_GAIN:      wet_gain  = data[sfd_pkg::WET_W-1:0];
            sfd_pkg::CFG_PING_PONG:     ping_pong = data[0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [sfd_pkg::CFG_DATA_W-1:0] dl,
                              logic [sfd_pkg::CFG_DATA_W-1:0] fb,
                              logic [sfd_pkg::CFG_DATA_W-1:0] wet,
                              logic [sfd_pkg::CFG_DATA_W-1:0] pp);
        cfg_write(sfd_pkg::CFG_DELAY_LENGTH, dl);
        cfg_write(sfd_pkg::CFG_FEEDBACK_GAIN, fb);
        cfg_write(sfd_pkg::CFG_WET_GAIN, wet);
        cfg_write(sfd_pkg::CFG_PING_PONG, pp);
    endtask

    task automatic send_phrase();
        int amp, len, k;
        amp = ($urandom_range(0, 9) < 5) ? 0 : int'($urandom_range(1, 2));
        if ($urandom_range(0, 6) == 0) begin
            // noise: arbitrary flags
            repeat ($urandom_range(1, 8))
                send_paced(make_word(amp, ($urandom_range(0, 1) == 1),
                                     ($urandom_range(0, 1) == 1)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                len = $urandom_range(1, 6);
                for (k = 1; k <= len; k++) send_paced(make_word(amp, 1'b1, k == len));
            end
            // tail frames without input
            repeat ($urandom_range(1, 6)) begin
                len = $urandom_range(1, 2);
                for (k = 1; k <= len; k++) send_paced(make_word(amp, 1'b0, k == len));
            end
        end
    endtask

    task automatic test_reset_state();
        send_word(make_word(1, 1'b0, 1'b1));
        send_word(make_word(1, 1'b0, 1'b0));
    endtask

    task automatic test_loudness_edges();
        send_word(fixed_word(32, -32, 1'b1, 1'b0));
        send_word(make_word(1, 1'b0, 1'b1));
        send_word(fixed_word(33, 0, 1'b1, 1'b0));
        repeat (4) send_word(make_word(1, 1'b0, 1'b1));
        send_word(fixed_word(0, -33, 1'b1, 1'b0));
        send_word(make_word(1, 1'b0, 1'b1));
    endtask

    task automatic test_sample_extremes();
        send_word(fixed_word(32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b1));
        send_word(fixed_word(32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1));
        send_word(fixed_word(32'hffff_ffff, 32'hffff_ffff, 1'b0, 1'b1));
    endtask

    task automatic test_ping_pong();
        wait_idle();
        set_config(1, 65535, 65536, 1);
        send_word(fixed_word(32'h7fff_ffff, 32'h7fff_ffff, 1'b1, 1'b0));
        send_word(fixed_word(32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0));
        send_word(fixed_word(32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1));
        send_word(fixed_word(-3, 0, 1'b1, 1'b1));
        send_word(make_word(1, 1'b0, 1'b1));
        send_word(make_word(1, 1'b0, 1'b1));
    endtask

    task automatic test_short_delay();
        wait_idle();
        set_config(0, 64225, 131071, 0);
        repeat (3) send_word(make_word(2, 1'b1, 1'b0));
        wait_idle();
        set_config(16383, 0, 0, 0);
        send_word(make_word(1, 1'b1, 1'b1));
        send_word(make_word(1, 1'b0, 1'b1));
    endtask

    task automatic test_backpressure();
        wait_idle();
        set_config(3, 40000, 65536, 1);
        stall_pct = 0;
        gap_max   = 0;
        holds_asked++;
        @(posedge clk);
        repeat (80) send_paced(make_word(1, ($urandom_range(0, 1) == 1),
                                         ($urandom_range(0, 1) == 1)));
        wait_idle();
    endtask

    task automatic test_random_phases(int total);
        int                             phase, target;
        logic [31:0]                    rnd;
        logic [sfd_pkg::CFG_DATA_W-1:0] dl, fb, wet, pp;
        for (phase = 0; phase < 8; phase++) begin
            wait_idle();
            rnd = $urandom();
            dl  = rnd[sfd_pkg::CFG_DATA_W-1:0];
            case ($urandom_range(0, 9))
                0: dl[sfd_pkg::DL_W-1:0] = '0;
                1: dl[sfd_pkg::DL_W-1:0] = '1;
                2: dl[sfd_pkg::DL_W-1:0] = 1;
                default: begin
                    rnd = $urandom_range(2, 48);
                    dl[sfd_pkg::DL_W-1:0] = rnd[sfd_pkg::DL_W-1:0];
                end
            endcase
            fb = '0;
            fb[sfd_pkg::FB_W] = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 5))
                0: fb[sfd_pkg::FB_W-1:0] = '0;
                1: fb[sfd_pkg::FB_W-1:0] = 64225;
                2: fb[sfd_pkg::FB_W-1:0] = 65535;
                default: begin
                    rnd = $urandom_range(0, 64225);
                    fb[sfd_pkg::FB_W-1:0] = rnd[sfd_pkg::FB_W-1:0];
                end
            endcase
            case ($urandom_range(0, 5))
                0: wet = '0;
                1: wet = 65536;
                2: wet = '1;
                default: begin
                    rnd = $urandom_range(0, 65536);
                    wet = rnd[sfd_pkg::CFG_DATA_W-1:0];
                end
            endcase
            rnd = $urandom();
            pp  = rnd[sfd_pkg::CFG_DATA_W-1:0];
            set_config(dl, fb, wet, pp);
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 30;
                default: stall_pct = 70;
            endcase
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 8;
            endcase
            target = sent_words + total / 8;
            while (sent_words < target) send_phrase();
        end
    endtask

    // receiver stall pattern, with long hold-offs on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left    <= HOLD_CYCLES;
            out_stall    <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        sfd_pkg::t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", out_word.out_left, '0);
            end else begin
                want = pending_words.pop_front();
                if (out_word.out_left !== want.out_left)
                    report_mismatch("out_left", out_word.out_left, want.out_left);
                if (out_word.out_right !== want.out_right)
                    report_mismatch("out_right", out_word.out_right, want.out_right);
                if (out_word.ringing !== want.ringing)
                    report_mismatch("ringing", 32'(out_word.ringing), 32'(want.ringing));
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_loudness_edges();
        test_sample_extremes();
        test_ping_pong();
        test_short_delay();
        test_backpressure();
        test_random_phases(1240);
        wait_idle();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
sv/sfd_pkg.sv
sv/sfd_ram.sv
sv/sfd_cfg.sv
sv/stereo_feedback_delay_unit.sv
tb/sv/tb_top.sv
